// ----- rtl/ps2mpt_pkg.sv -----
// Shared types and constants for the PS/2 mouse position tracker.
// No dependencies; imported by the top level, the framer and the accumulator.
`timescale 1ns / 1ps

package ps2mpt_pkg;

  localparam int unsigned COORD_W        = 10;
  localparam int unsigned BUTTON_W       = 3;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned PKT_FIFO_DEPTH = 4;

  localparam logic [BYTE_W-1:0]   FRAME_BIT   = 8'h08;
  localparam logic [BYTE_W-1:0]   BUTTON_MASK = 8'h07;
  localparam logic [COORD_W-1:0]  LIMIT_RESET = 10'd300;
  localparam logic [COORD_W-1:0]  X_RESET     = 10'd40;
  localparam logic [COORD_W-1:0]  Y_RESET     = 10'd12;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_LIMIT = 2'd1;

  // Byte position inside a packet
  typedef enum logic [1:0] {
    PH_FLAGS,
    PH_DX,
    PH_DY
  } phase_t;

  // One complete packet handed from the framer to the accumulator
  typedef struct packed {
    logic [BUTTON_W-1:0]     buttons;
    logic signed [BYTE_W-1:0] dx;
    logic signed [BYTE_W-1:0] dy;
  } pkt_t;

  localparam int unsigned PKT_W = $bits(pkt_t);

endpackage

// ----- rtl/ps2_mouse_position_tracker_unit.sv -----
// Top level of the PS/2 mouse position tracker.
// Depends on ps2mpt_pkg, ps2mpt_framer, ps2mpt_fifo and ps2mpt_accum.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive one received device byte on in_rx_byte with in_push;
//   the transaction completes at a clock edge where in_full is low. Bytes of
//   a packet (flags, X delta, Y delta) may arrive in consecutive cycles; a
//   flags byte with bit 3 clear is dropped to regain framing.
//   Result channel: after the third byte of a packet one result appears;
//   while out_empty is low, out_pos_x, out_pos_y and out_button_bits hold it
//   and an edge with out_pop high takes it.
//   Path: a completed packet is written into the packet queue and then into
//   the result register, when the result slot is free or drained.
//   Throughput: one byte per cycle, no gap between packets, while in_full is
//   low; the accumulator takes one packet per cycle unless its result waits.
//   Stalls: while the result is not taken, completed packets wait in a
//   FIFO_DEPTH-entry queue; in_full is high only while a third byte is due
//   and that queue is full, so first and second bytes are still accepted.
//   Configuration: cfg_we with cfg_index 0 (X limit) or 1 (Y limit) writes
//   cfg_wdata; other indexes are ignored. Write only while idle.
//   Reset (synchronous, rst_n low): position 40,12, buttons clear, limits 300,
//   framing back to the flags byte, queues empty.
module ps2_mouse_position_tracker_unit #(
  parameter int unsigned FIFO_DEPTH = ps2mpt_pkg::PKT_FIFO_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [ps2mpt_pkg::COORD_W-1:0]     out_pos_x,
  output logic [ps2mpt_pkg::COORD_W-1:0]     out_pos_y,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]    out_button_bits,
  input  logic                               cfg_we,
  input  logic [ps2mpt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ps2mpt_pkg::COORD_W-1:0]     cfg_wdata
);
  import ps2mpt_pkg::*;

  logic        fr_push, q_full, q_empty, q_pop;
  pkt_t        fr_pkt, q_pkt;
  logic [PKT_W-1:0] q_rdata;

  ps2mpt_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .pkt_push   (fr_push),
    .pkt_full   (q_full),
    .pkt_data   (fr_pkt)
  );

  ps2mpt_fifo #(
    .DATA_W (PKT_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata (fr_pkt),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_pkt = pkt_t'(q_rdata);

  ps2mpt_accum u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pkt_empty       (q_empty),
    .pkt_data        (q_pkt),
    .pkt_pop         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_button_bits (out_button_bits)
  );

endmodule

// ----- rtl/ps2mpt_framer.sv -----
// Front part: tracks the byte phase, drops unframed flags bytes and
// assembles complete packets. Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_framer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [ps2mpt_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                         pkt_push,
  input  logic                         pkt_full,
  output ps2mpt_pkg::pkt_t             pkt_data
);
  import ps2mpt_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flags_r;
  logic [BYTE_W-1:0]   dx_r;
  logic                accept;

  // Stall only when the third byte has nowhere to go
  assign in_full = pkt_full && (phase_r == PH_DY);
  assign accept  = in_push && !in_full;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_FLAGS: phase_nxt = ((in_rx_byte & FRAME_BIT) != '0) ? PH_DX : PH_FLAGS;
        PH_DX:    phase_nxt = PH_DY;
        PH_DY:    phase_nxt = PH_FLAGS;
        default:  phase_nxt = PH_FLAGS;
      endcase
    end
  end

  // Packet outputs
  always_comb begin
    pkt_push         = accept && (phase_r == PH_DY);
    pkt_data.buttons = flags_r[BUTTON_W-1:0] & BUTTON_MASK[BUTTON_W-1:0];
    pkt_data.dx      = dx_r;
    pkt_data.dy      = in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Capture flags and X delta bytes
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_FLAGS)) begin
      flags_r <= in_rx_byte;
    end
    if (accept && (phase_r == PH_DX)) begin
      dx_r <= in_rx_byte;
    end
  end

endmodule

// ----- rtl/ps2mpt_fifo.sv -----
// Short packet queue between the framer and the accumulator.
// Generic width and depth; no dependencies.
`timescale 1ns / 1ps

module ps2mpt_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("packet queue over-filled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push offered to a full packet queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy lost a push");

endmodule

// ----- rtl/ps2mpt_accum.sv -----
// Back part: applies each packet to the position with saturation and
// holds the result register. Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_accum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ps2mpt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ps2mpt_pkg::COORD_W-1:0]     cfg_wdata,
  input  logic                               pkt_empty,
  input  ps2mpt_pkg::pkt_t                   pkt_data,
  output logic                               pkt_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [ps2mpt_pkg::COORD_W-1:0]     out_pos_x,
  output logic [ps2mpt_pkg::COORD_W-1:0]     out_pos_y,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]    out_button_bits
);
  import ps2mpt_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  logic [COORD_W-1:0]      x_limit_r, y_limit_r;
  logic [COORD_W-1:0]      cur_x_r, cur_y_r;
  logic [BUTTON_W-1:0]     cur_buttons_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] nx, ny;
  logic [COORD_W-1:0]      cx, cy;

  // Take a packet whenever the result slot is free or being drained
  assign pkt_pop   = !pkt_empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  // Add X delta, subtract Y delta (device Y axis is inverted)
  assign nx = $signed({2'b00, cur_x_r}) + SUM_W'(pkt_data.dx);
  assign ny = $signed({2'b00, cur_y_r}) - SUM_W'(pkt_data.dy);

  // Saturate to the range from zero to the limit
  always_comb begin
    priority if (nx < 0) begin
      cx = '0;
    end else if (nx[SUM_W-2:0] > {1'b0, x_limit_r}) begin
      cx = x_limit_r;
    end else begin
      cx = nx[COORD_W-1:0];
    end
    priority if (ny < 0) begin
      cy = '0;
    end else if (ny[SUM_W-2:0] > {1'b0, y_limit_r}) begin
      cy = y_limit_r;
    end else begin
      cy = ny[COORD_W-1:0];
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= LIMIT_RESET;
      y_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_X_LIMIT) begin
        x_limit_r <= cfg_wdata;
      end else if (cfg_index == REG_Y_LIMIT) begin
        y_limit_r <= cfg_wdata;
      end
    end
  end

  // Position state and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= X_RESET;
      cur_y_r       <= Y_RESET;
      cur_buttons_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pkt_pop) begin
        cur_x_r       <= cx;
        cur_y_r       <= cy;
        cur_buttons_r <= pkt_data.buttons;
        out_valid_r   <= 1'b1;
      end else if (out_pop) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  assign out_pos_x       = cur_x_r;
  assign out_pos_y       = cur_y_r;
  assign out_button_bits = cur_buttons_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> ($stable(cur_x_r) && $stable(cur_y_r)))
    else $error("result overwritten before it was taken");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_pop |-> (!out_valid_r || out_pop))
    else $error("packet drained with the result slot busy");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_pop |=> out_valid_r) else $error("drained packet produced no result");

endmodule
